>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active-low reset).
`define SC1A_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SC1A_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sc1a_pkg.sv
// Types, scan codes and translation tables for the scan code set 1 translator.
package sc1a_pkg;

  // Special scan bytes
  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [7:0] SC_BREAK   = 8'h80;
  localparam logic [7:0] SC_UP      = 8'h48;
  localparam logic [7:0] SC_DOWN    = 8'h50;
  localparam logic [7:0] SC_LEFT    = 8'h4B;
  localparam logic [7:0] SC_RIGHT   = 8'h4D;
  localparam logic [7:0] SC_SHIFT_L = 8'h2A;
  localparam logic [7:0] SC_SHIFT_R = 8'h36;
  localparam logic [7:0] SC_CTRL    = 8'h1D;
  localparam logic [7:0] SC_CAPS    = 8'h3A;

  localparam logic [7:0] TABLE_LEN     = 8'd89;
  localparam logic [7:0] LET_A         = 8'h61;
  localparam logic [7:0] LET_Z         = 8'h7A;
  localparam logic [7:0] CTRL_DROP_MAX = 8'd4;

  localparam logic [7:0] ARROW_UP_RST    = 8'd1;
  localparam logic [7:0] ARROW_DOWN_RST  = 8'd2;
  localparam logic [7:0] ARROW_LEFT_RST  = 8'd3;
  localparam logic [7:0] ARROW_RIGHT_RST = 8'd4;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_ARROW_UP    = 2'd0,
    REG_ARROW_DOWN  = 2'd1,
    REG_ARROW_LEFT  = 2'd2,
    REG_ARROW_RIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] left;
    logic [7:0] right;
  } arrow_codes_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] code;
  } xlate_res_t;

  function automatic logic [7:0] plain_map(input logic [6:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      7'h02: ch = "1";   7'h03: ch = "2";   7'h04: ch = "3";   7'h05: ch = "4";
      7'h06: ch = "5";   7'h07: ch = "6";   7'h08: ch = "7";   7'h09: ch = "8";
      7'h0A: ch = "9";   7'h0B: ch = "0";   7'h0C: ch = "-";   7'h0D: ch = "=";
      7'h0E: ch = 8'h08; 7'h0F: ch = 8'h09;
      7'h10: ch = "q";   7'h11: ch = "w";   7'h12: ch = "e";   7'h13: ch = "r";
      7'h14: ch = "t";   7'h15: ch = "y";   7'h16: ch = "u";   7'h17: ch = "i";
      7'h18: ch = "o";   7'h19: ch = "p";   7'h1A: ch = "[";   7'h1B: ch = "]";
      7'h1C: ch = 8'h0A;
      7'h1E: ch = "a";   7'h1F: ch = "s";   7'h20: ch = "d";   7'h21: ch = "f";
      7'h22: ch = "g";   7'h23: ch = "h";   7'h24: ch = "j";   7'h25: ch = "k";
      7'h26: ch = "l";   7'h27: ch = ";";   7'h28: ch = 8'h27; 7'h29: ch = 8'h60;
      7'h2B: ch = 8'h5C;
      7'h2C: ch = "z";   7'h2D: ch = "x";   7'h2E: ch = "c";   7'h2F: ch = "v";
      7'h30: ch = "b";   7'h31: ch = "n";   7'h32: ch = "m";   7'h33: ch = ",";
      7'h34: ch = ".";   7'h35: ch = "/";   7'h37: ch = "*";   7'h39: ch = " ";
      7'h47: ch = "7";   7'h48: ch = "8";   7'h49: ch = "9";   7'h4A: ch = "-";
      7'h4B: ch = "4";   7'h4C: ch = "5";   7'h4D: ch = "6";   7'h4E: ch = "+";
      7'h4F: ch = "1";   7'h50: ch = "2";   7'h51: ch = "3";   7'h52: ch = "0";
      7'h53: ch = ".";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] upper_map(input logic [6:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      7'h02: ch = "!";   7'h03: ch = "@";   7'h04: ch = "#";   7'h05: ch = "$";
      7'h06: ch = "%";   7'h07: ch = "^";   7'h08: ch = "&";   7'h09: ch = "*";
      7'h0A: ch = "(";   7'h0B: ch = ")";   7'h0C: ch = "_";   7'h0D: ch = "+";
      7'h0E: ch = 8'h08; 7'h0F: ch = 8'h09;
      7'h10: ch = "Q";   7'h11: ch = "W";   7'h12: ch = "E";   7'h13: ch = "R";
      7'h14: ch = "T";   7'h15: ch = "Y";   7'h16: ch = "U";   7'h17: ch = "I";
      7'h18: ch = "O";   7'h19: ch = "P";   7'h1A: ch = "{";   7'h1B: ch = "}";
      7'h1C: ch = 8'h0A;
      7'h1E: ch = "A";   7'h1F: ch = "S";   7'h20: ch = "D";   7'h21: ch = "F";
      7'h22: ch = "G";   7'h23: ch = "H";   7'h24: ch = "J";   7'h25: ch = "K";
      7'h26: ch = "L";   7'h27: ch = ":";   7'h28: ch = 8'h22; 7'h29: ch = "~";
      7'h2B: ch = "|";
      7'h2C: ch = "Z";   7'h2D: ch = "X";   7'h2E: ch = "C";   7'h2F: ch = "V";
      7'h30: ch = "B";   7'h31: ch = "N";   7'h32: ch = "M";   7'h33: ch = "<";
      7'h34: ch = ">";   7'h35: ch = "?";   7'h37: ch = "*";   7'h39: ch = " ";
      7'h47: ch = "7";   7'h48: ch = "8";   7'h49: ch = "9";   7'h4A: ch = "-";
      7'h4B: ch = "4";   7'h4C: ch = "5";   7'h4D: ch = "6";   7'h4E: ch = "+";
      7'h4F: ch = "1";   7'h50: ch = "2";   7'h51: ch = "3";   7'h52: ch = "0";
      7'h53: ch = ".";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/scan_code_set1_to_ascii.sv
// Top level of the scan code set 1 to ASCII translator.
// Translates one scan code set 1 byte per input word into at most one character
// word (US layout), tracking shift, left ctrl, caps lock and the extended prefix.
// A byte is registered on acceptance, then decoded and applied to the modifier
// flags, and its character, if any, is registered into the result register that
// drives out_valid. The single decode stage between the input and result
// registers sustains one byte per clock unless a character waits on a held
// result register; in_stall rises only while a character is pending and the
// result register is held by out_stall. The arrow codes sit at byte addresses
// 0, 4, 8 and 12 of the APB port.
module scan_code_set1_to_ascii (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_scan_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_char_code,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sc1a_pkg::APB_AW-1:0] paddr,
  input  logic [sc1a_pkg::APB_DW-1:0] pwdata,
  output logic [sc1a_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import sc1a_pkg::*;

  arrow_codes_t arrows;
  xlate_res_t   res;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic [7:0] out_code_r;
  logic       out_free, s1_go, s1_load;

  assign pready = 1'b1;

  sc1a_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .arrows  (arrows)
  );

  sc1a_xlate u_xlate (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_go),
    .scan_byte (s1_byte_r),
    .arrows    (arrows),
    .res       (res)
  );

  // A byte without a character retires even while the result register is held.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!res.emit || out_free);
  assign s1_load  = !s1_valid_r || s1_go;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_byte_r <= in_scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      out_code_r <= res.code;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_code_r;

endmodule

>>> rtl/sc1a_regs.sv
// APB register file holding the four arrow key codes.
module sc1a_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sc1a_pkg::APB_AW-1:0] paddr,
  input  logic [sc1a_pkg::APB_DW-1:0] pwdata,
  output logic [sc1a_pkg::APB_DW-1:0] prdata,
  output sc1a_pkg::arrow_codes_t      arrows
);
  import sc1a_pkg::*;

  arrow_codes_t arrows_r;
  reg_idx_t     idx;
  logic         wr_en;
  logic [7:0]   rd_byte;

  assign idx   = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrows_r.up    <= ARROW_UP_RST;
      arrows_r.down  <= ARROW_DOWN_RST;
      arrows_r.left  <= ARROW_LEFT_RST;
      arrows_r.right <= ARROW_RIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ARROW_UP:    arrows_r.up    <= pwdata[7:0];
        REG_ARROW_DOWN:  arrows_r.down  <= pwdata[7:0];
        REG_ARROW_LEFT:  arrows_r.left  <= pwdata[7:0];
        REG_ARROW_RIGHT: arrows_r.right <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ARROW_UP:    rd_byte = arrows_r.up;
      REG_ARROW_DOWN:  rd_byte = arrows_r.down;
      REG_ARROW_LEFT:  rd_byte = arrows_r.left;
      REG_ARROW_RIGHT: rd_byte = arrows_r.right;
      default:         rd_byte = 8'h00;
    endcase
  end

  assign prdata = {{(APB_DW-8){1'b0}}, rd_byte};
  assign arrows = arrows_r;

endmodule

>>> rtl/sc1a_xlate.sv
// Modifier flags and single-byte translation to a character code.
module sc1a_xlate (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [7:0]             scan_byte,
  input  sc1a_pkg::arrow_codes_t arrows,
  output sc1a_pkg::xlate_res_t   res
);
  import sc1a_pkg::*;

  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic caps_r, caps_nxt;
  logic prefix_r, prefix_nxt;

  logic [7:0] lo_ch, hi_ch, ch, ctrl_ch;
  logic       letter, upper;

  assign lo_ch   = plain_map(scan_byte[6:0]);
  assign hi_ch   = upper_map(scan_byte[6:0]);
  assign letter  = (lo_ch >= LET_A) && (lo_ch <= LET_Z);
  assign upper   = letter ? (shift_r ^ caps_r) : shift_r;
  assign ch      = upper ? hi_ch : lo_ch;
  assign ctrl_ch = lo_ch - LET_A + 8'd1;

  always_comb begin
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    caps_nxt   = caps_r;
    prefix_nxt = prefix_r;
    res.emit   = 1'b0;
    res.code   = 8'h00;
    if (scan_byte == SC_PREFIX) begin
      prefix_nxt = 1'b1;
    end else if (prefix_r) begin
      // extended code: only the arrow makes produce a word
      prefix_nxt = 1'b0;
      case (scan_byte)
        SC_UP: begin
          res.emit = 1'b1;
          res.code = arrows.up;
        end
        SC_DOWN: begin
          res.emit = 1'b1;
          res.code = arrows.down;
        end
        SC_LEFT: begin
          res.emit = 1'b1;
          res.code = arrows.left;
        end
        SC_RIGHT: begin
          res.emit = 1'b1;
          res.code = arrows.right;
        end
        default: ;
      endcase
    end else if (scan_byte == (SC_SHIFT_L | SC_BREAK) ||
                 scan_byte == (SC_SHIFT_R | SC_BREAK)) begin
      shift_nxt = 1'b0;
    end else if (scan_byte == (SC_CTRL | SC_BREAK)) begin
      ctrl_nxt = 1'b0;
    end else if (scan_byte[7]) begin
      // drop other releases
    end else if (scan_byte == SC_SHIFT_L || scan_byte == SC_SHIFT_R) begin
      shift_nxt = 1'b1;
    end else if (scan_byte == SC_CTRL) begin
      ctrl_nxt = 1'b1;
    end else if (scan_byte == SC_CAPS) begin
      caps_nxt = !caps_r;
    end else if (scan_byte < TABLE_LEN && ch != 8'h00) begin
      if (ctrl_r && letter) begin
        // ctrl-a through ctrl-d are dropped
        if (ctrl_ch > CTRL_DROP_MAX) begin
          res.emit = 1'b1;
          res.code = ctrl_ch;
        end
      end else begin
        res.emit = 1'b1;
        res.code = ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      ctrl_r   <= 1'b0;
      caps_r   <= 1'b0;
      prefix_r <= 1'b0;
    end else if (fire) begin
      shift_r  <= shift_nxt;
      ctrl_r   <= ctrl_nxt;
      caps_r   <= caps_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

>>> rtl/sc1a_chk.sv
// Port-level checker for the scan code translator, bound to the top level.
`include "assert_macros.svh"

module sc1a_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char_code
);

  // hold a stalled result word
  `SC1A_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_char_code), "stalled result word changed")

  // an empty result register never backs up the input
  `SC1A_ASSERT(a_no_idle_stall, clk, rst_n, !out_valid |-> !in_stall, "input stalled with result register empty")

  // a fresh result traces back to an accepted input word
  `SC1A_ASSERT(a_rise_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result word without an accepted input word")

  // reset empties the pipeline
  `SC1A_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind scan_code_set1_to_ascii sc1a_chk u_sc1a_chk (.*);
